### hdl/mbr_pkg.sv
`timescale 1ns / 1ps

package mbr_pkg;

   // Largest source level the line store is sized for.
   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;

   // Register widths fixed by the register map.
   localparam int CSR_SIZE_W = 13;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 2;

   // Position counters and effective sizes.
   localparam int COL_W  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W  = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
   localparam int EFFW_W = COL_W + 1;
   localparam int EFFH_W = ROW_W + 1;

   // The line store keeps the top row as column pairs, one pair per word.
   localparam int STORE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   // Linear light is unsigned Q0.16, 65535 = 1.0.
   localparam int LIN_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_SRGB_MODE  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   // hi is the odd column, lo the even column to its left
   typedef struct packed {
      pixel_type hi;
      pixel_type lo;
   } pixel_pair_type;

   // Table build constants; everything below runs at elaboration only.
   // Codes are taken over a denominator of 510 so that decode points (2k/510)
   // and code midpoints ((2k-1)/510) share one formula.
   localparam logic [63:0] SRGB_DEN  = 64'd510;
   localparam logic [63:0] LIN_DEN   = 64'd1292 * SRGB_DEN;
   localparam logic [63:0] POW_DEN   = 64'd1055 * SRGB_DEN;
   localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
   localparam logic [63:0] Q30_HALF  = 64'd1 << 29;
   localparam logic [63:0] KNEE_NUM  = 64'd4045;
   localparam logic [63:0] KNEE_DEN  = 64'd100000;

   function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
      return (a * b) >> 30;
   endfunction

   function automatic logic [63:0] pow5_q30(input logic [63:0] r);
      logic [63:0] r2;
      r2 = mul_q30(r, r);
      return mul_q30(mul_q30(r2, r2), r);
   endfunction

   // 65535 * lin(num/510), rounded to nearest or up
   function automatic logic [LIN_W-1:0] lin_value(input logic [63:0] num, input logic up);
      logic [63:0] a;
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      logic [63:0] q;
      if (num * KNEE_DEN <= KNEE_NUM * SRGB_DEN) begin
         a = 64'd6553500 * num;
         if (up) begin
            q = (a + LIN_DEN - 64'd1) / LIN_DEN;
         end else begin
            q = (a + LIN_DEN / 64'd2) / LIN_DEN;
         end
      end else begin
         t = ((64'd1000 * num + 64'd55 * SRGB_DEN) << 30) / POW_DEN;
         if (t > Q30_ONE) begin
            t = Q30_ONE;
         end
         t2 = mul_q30(t, t);
         // t^2.4 = t^2 * (t^2)^(1/5); fifth root by bisection, truncating
         lo = 64'd0;
         hi = Q30_ONE;
         for (int i = 0; i < 32; i++) begin
            if (lo < hi) begin
               mid = (lo + hi + 64'd1) >> 1;
               if (pow5_q30(mid) <= t2) begin
                  lo = mid;
               end else begin
                  hi = mid - 64'd1;
               end
            end
         end
         a = mul_q30(t2, lo) * 64'd65535;
         if (up) begin
            q = (a + Q30_ONE - 64'd1) >> 30;
         end else begin
            q = (a + Q30_HALF) >> 30;
         end
      end
      return q[LIN_W-1:0];
   endfunction

   function automatic logic [LIN_W-1:0] srgb_decode(input int unsigned k);
      return lin_value(64'(2 * k), 1'b0);
   endfunction

   // Lowest linear value that re-encodes to code k.
   function automatic logic [LIN_W-1:0] srgb_threshold(input int unsigned k);
      if (k == 0) begin
         return '0;
      end
      return lin_value(64'(2 * k - 1), 1'b1);
   endfunction

endpackage

### hdl/mbr_line_store.sv
`timescale 1ns / 1ps

module mbr_line_store (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [mbr_pkg::STORE_AW-1:0]    wr_addr,
   input  mbr_pkg::pixel_pair_type         wr_data,
   input  logic                            rd_en,
   input  logic [mbr_pkg::STORE_AW-1:0]    rd_addr,
   output mbr_pkg::pixel_pair_type         rd_data
);

   mbr_pkg::pixel_pair_type mem [mbr_pkg::STORE_DEPTH];
   mbr_pkg::pixel_pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds while the consumer stage is stalled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/mbr_encode.sv
`timescale 1ns / 1ps

module mbr_encode (
   input  logic [mbr_pkg::LIN_W-1:0] lin,
   output logic [7:0]                code
);

   logic [mbr_pkg::LIN_W-1:0] thr_tab [256];

   for (genvar k = 0; k < 256; k++) begin : g_thr
      localparam logic [mbr_pkg::LIN_W-1:0] ThrVal = mbr_pkg::srgb_threshold(k);
      assign thr_tab[k] = ThrVal;
   end

   // Thresholds rise with the code, so the largest code whose threshold is
   // not above lin falls out of a bitwise search, MSB first.
   always_comb begin
      logic [7:0] acc;
      logic [7:0] trial;
      acc = '0;
      for (int b = 7; b >= 0; b--) begin
         trial = acc | (8'd1 << b);
         if (thr_tab[trial] <= lin) begin
            acc = trial;
         end
      end
      code = acc;
   end

endmodule

### hdl/mip_box_reduce_srgb.sv
`timescale 1ns / 1ps

// 2x2 box reducer for one mip level of an RGBA8 raster stream. Source pixels
// are taken one per cycle while req_stall is low, with no gaps required; the
// reduced pixel for a box moves through three registered stages (input stage
// with line store read, linear average stage, encode/output register) after
// the beat carrying its bottom-right pixel; a result-side stall backs up through those three
// stages only. The destination is max(1, size/2) per axis; an odd trailing
// row or column is dropped, and rsp_last_of_level marks the final pixel.
// Writing any register restarts the level. srgb_mode averages red, green and
// blue in linear light; alpha is always a plain rounded average.
module mip_box_reduce_srgb (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             csr_wr_en,
   input  logic [mbr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mbr_pkg::CSR_DATA_W-1:0]   csr_wr_data,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_red,
   input  logic [7:0]                       req_green,
   input  logic [7:0]                       req_blue,
   input  logic [7:0]                       req_alpha,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_red,
   output logic [7:0]                       rsp_green,
   output logic [7:0]                       rsp_blue,
   output logic [7:0]                       rsp_alpha,
   output logic                             rsp_last_of_level
);

   localparam int CmpW   = (mbr_pkg::CSR_SIZE_W > mbr_pkg::EFFW_W + 1) ?
                           mbr_pkg::CSR_SIZE_W : mbr_pkg::EFFW_W + 1;
   localparam int CmpHW  = (mbr_pkg::CSR_SIZE_W > mbr_pkg::EFFH_W + 1) ?
                           mbr_pkg::CSR_SIZE_W : mbr_pkg::EFFH_W + 1;
   localparam int LinW   = mbr_pkg::LIN_W;

   // ---------------- configuration ----------------
   logic [mbr_pkg::CSR_SIZE_W-1:0] src_width_ff;
   logic [mbr_pkg::CSR_SIZE_W-1:0] src_height_ff;
   logic                           srgb_mode_ff;
   logic                           restart;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= mbr_pkg::CSR_SIZE_W'(1);
         src_height_ff <= mbr_pkg::CSR_SIZE_W'(1);
         srgb_mode_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (mbr_pkg::csr_index_type'(csr_index))
            mbr_pkg::CSR_SRC_WIDTH: begin
               src_width_ff <= csr_wr_data[mbr_pkg::CSR_SIZE_W-1:0];
            end
            mbr_pkg::CSR_SRC_HEIGHT: begin
               src_height_ff <= csr_wr_data[mbr_pkg::CSR_SIZE_W-1:0];
            end
            mbr_pkg::CSR_SRGB_MODE: begin
               srgb_mode_ff <= csr_wr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (mbr_pkg::csr_index_type'(csr_index))
         mbr_pkg::CSR_SRC_WIDTH,
         mbr_pkg::CSR_SRC_HEIGHT,
         mbr_pkg::CSR_SRGB_MODE: restart = csr_wr_en;
         default:                restart = 1'b0;
      endcase
   end

   // effective sizes, clamped to 1..MAX
   logic [mbr_pkg::EFFW_W-1:0] eff_w;
   logic [mbr_pkg::EFFH_W-1:0] eff_h;

   always_comb begin
      if (src_width_ff == '0) begin
         eff_w = mbr_pkg::EFFW_W'(1);
      end else if (CmpW'(src_width_ff) > CmpW'(mbr_pkg::MAX_WIDTH)) begin
         eff_w = mbr_pkg::EFFW_W'(mbr_pkg::MAX_WIDTH);
      end else begin
         eff_w = mbr_pkg::EFFW_W'(src_width_ff);
      end
      if (src_height_ff == '0) begin
         eff_h = mbr_pkg::EFFH_W'(1);
      end else if (CmpHW'(src_height_ff) > CmpHW'(mbr_pkg::MAX_HEIGHT)) begin
         eff_h = mbr_pkg::EFFH_W'(mbr_pkg::MAX_HEIGHT);
      end else begin
         eff_h = mbr_pkg::EFFH_W'(src_height_ff);
      end
   end

   // ---------------- pipeline flow control ----------------
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic out_valid_ff;
   logic out_ready;
   logic s2_ready;
   logic s1_ready;
   logic accept;

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;
   assign accept    = req_valid && s1_ready;

   // ---------------- raster position ----------------
   logic [mbr_pkg::COL_W-1:0] col_ff, col_in, col;
   logic [mbr_pkg::ROW_W-1:0] row_ff, row_in, row;
   mbr_pkg::pixel_type        held_left_ff, held_left_in;
   mbr_pkg::pixel_type        cur;
   logic                      w_one, h_one;
   logic                      col_ok, row_ok, emit, last_box;
   logic [mbr_pkg::EFFW_W-1:0] col_inc;
   logic [mbr_pkg::EFFH_W-1:0] row_inc;
   logic                      st_wr;
   logic                      st_rd;
   logic [mbr_pkg::STORE_AW-1:0] st_addr;
   mbr_pkg::pixel_pair_type   st_wr_data;
   mbr_pkg::pixel_pair_type   st_rd_data;

   assign cur = '{alpha: req_alpha, blue: req_blue, green: req_green, red: req_red};

   always_comb begin
      w_one = (eff_w == mbr_pkg::EFFW_W'(1));
      h_one = (eff_h == mbr_pkg::EFFH_W'(1));
      if (mbr_pkg::EFFW_W'(col_ff) >= eff_w || mbr_pkg::EFFH_W'(row_ff) >= eff_h) begin
         col = '0;
         row = '0;
      end else begin
         col = col_ff;
         row = row_ff;
      end
      col_inc = mbr_pkg::EFFW_W'(col) + mbr_pkg::EFFW_W'(1);
      row_inc = mbr_pkg::EFFH_W'(row) + mbr_pkg::EFFH_W'(1);

      // an odd position is always inside the even-rounded size
      col_ok   = w_one || col[0];
      row_ok   = h_one || row[0];
      emit     = col_ok && row_ok;
      last_box = (w_one || col_inc == {eff_w[mbr_pkg::EFFW_W-1:1], 1'b0}) &&
                 (h_one || row_inc == {eff_h[mbr_pkg::EFFH_W-1:1], 1'b0});

      // top row saved as column pairs on the even row of each row pair
      st_addr         = mbr_pkg::STORE_AW'(col >> 1);
      st_wr           = accept && !h_one && !row[0] && (w_one || col[0]);
      st_wr_data.hi   = cur;
      st_wr_data.lo   = w_one ? cur : held_left_ff;
      st_rd           = accept && emit && !h_one;

      held_left_in = held_left_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      if (restart) begin
         held_left_in = '0;
         col_in       = '0;
         row_in       = '0;
      end else if (accept) begin
         if (!col[0]) begin
            held_left_in = cur;
         end
         if (col_inc >= eff_w) begin
            col_in = '0;
            if (row_inc >= eff_h) begin
               row_in = '0;
            end else begin
               row_in = row_inc[mbr_pkg::ROW_W-1:0];
            end
         end else begin
            col_in = col_inc[mbr_pkg::COL_W-1:0];
            row_in = row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_left_ff <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
      end else begin
         held_left_ff <= held_left_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
      end
   end

   mbr_line_store u_line_store (
      .clock   (clock),
      .wr_en   (st_wr),
      .wr_addr (st_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd),
      .rd_addr (st_addr),
      .rd_data (st_rd_data)
   );

   // ---------------- stage 1: box gather ----------------
   mbr_pkg::pixel_type s1_cur_ff;
   mbr_pkg::pixel_type s1_left_ff;
   logic               s1_h_one_ff;
   logic               s1_srgb_ff;
   logic               s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= accept && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         s1_cur_ff   <= cur;
         s1_left_ff  <= w_one ? cur : held_left_ff;
         s1_h_one_ff <= h_one;
         s1_srgb_ff  <= srgb_mode_ff;
         s1_last_ff  <= last_box;
      end
   end

   logic [LinW-1:0] dec_tab [256];

   for (genvar k = 0; k < 256; k++) begin : g_dec
      localparam logic [LinW-1:0] DecVal = mbr_pkg::srgb_decode(k);
      assign dec_tab[k] = DecVal;
   end

   mbr_pkg::pixel_type box [4];
   logic [7:0]         bchan [4][4];
   logic [LinW-1:0]    s2_lin_in [3];
   logic [7:0]         s2_alpha_in;

   always_comb begin
      logic [LinW+1:0] lsum;
      logic [9:0]      psum;
      if (s1_h_one_ff) begin
         box[0] = s1_left_ff;
         box[1] = s1_cur_ff;
      end else begin
         box[0] = st_rd_data.lo;
         box[1] = st_rd_data.hi;
      end
      box[2] = s1_left_ff;
      box[3] = s1_cur_ff;
      for (int p = 0; p < 4; p++) begin
         bchan[p][0] = box[p].red;
         bchan[p][1] = box[p].green;
         bchan[p][2] = box[p].blue;
         bchan[p][3] = box[p].alpha;
      end
      for (int c = 0; c < 3; c++) begin
         lsum = (LinW+2)'(dec_tab[bchan[0][c]]) + (LinW+2)'(dec_tab[bchan[1][c]]) +
                (LinW+2)'(dec_tab[bchan[2][c]]) + (LinW+2)'(dec_tab[bchan[3][c]]);
         psum = 10'(bchan[0][c]) + 10'(bchan[1][c]) + 10'(bchan[2][c]) + 10'(bchan[3][c]);
         if (s1_srgb_ff) begin
            s2_lin_in[c] = LinW'((lsum + (LinW+2)'(2)) >> 2);
         end else begin
            s2_lin_in[c] = LinW'((psum + 10'd2) >> 2);
         end
      end
      psum = 10'(bchan[0][3]) + 10'(bchan[1][3]) + 10'(bchan[2][3]) + 10'(bchan[3][3]);
      s2_alpha_in = 8'((psum + 10'd2) >> 2);
   end

   // ---------------- stage 2: linear average ----------------
   logic [LinW-1:0] s2_lin_ff [3];
   logic [7:0]      s2_alpha_ff;
   logic            s2_srgb_ff;
   logic            s2_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_lin_ff   <= s2_lin_in;
         s2_alpha_ff <= s2_alpha_in;
         s2_srgb_ff  <= s1_srgb_ff;
         s2_last_ff  <= s1_last_ff;
      end
   end

   logic [7:0] enc_code [3];
   logic [7:0] out_chan_in [3];

   for (genvar c = 0; c < 3; c++) begin : g_enc
      mbr_encode u_encode (
         .lin  (s2_lin_ff[c]),
         .code (enc_code[c])
      );
      assign out_chan_in[c] = s2_srgb_ff ? enc_code[c] : s2_lin_ff[c][7:0];
   end

   // ---------------- output register ----------------
   logic [7:0] out_red_ff, out_green_ff, out_blue_ff, out_alpha_ff;
   logic       out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s2_valid_ff) begin
         out_red_ff   <= out_chan_in[0];
         out_green_ff <= out_chan_in[1];
         out_blue_ff  <= out_chan_in[2];
         out_alpha_ff <= s2_alpha_ff;
         out_last_ff  <= s2_last_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_red           = out_red_ff;
   assign rsp_green         = out_green_ff;
   assign rsp_blue          = out_blue_ff;
   assign rsp_alpha         = out_alpha_ff;
   assign rsp_last_of_level = out_last_ff;

`ifndef SYNTHESIS
   // positions stay inside the level; a size write restarts them at once
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      mbr_pkg::EFFW_W'(col_ff) < eff_w)
      else $error("column position beyond source width");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      mbr_pkg::EFFH_W'(row_ff) < eff_h)
      else $error("row position beyond source height");

   // top row is written on even rows and read on odd rows only
   a_store_no_collide: assert property (@(posedge clock) disable iff (reset)
      !(st_wr && st_rd))
      else $error("line store read and write in the same cycle");

   // a box waiting in stage 1 is not lost when stage 2 is blocked
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_ready |=> s1_valid_ff && $stable(s1_cur_ff))
      else $error("stage 1 box dropped under backpressure");

   // input only backs up when every stage holds a box
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s2_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled with a free stage");
`endif

endmodule

### sim/mip_box_reduce_srgb_tb.sv
`timescale 1ns / 1ps

module mip_box_reduce_srgb_tb;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int PIPE_SETTLE  = 8;
   localparam int RANDOM_ITEMS = 1050;
   // not in the map, write is dropped
   localparam logic [mbr_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam longint unsigned UNIT_Q30 = 64'd1 << 30;

   typedef struct packed {
      mbr_pkg::pixel_type px;
      logic               last;
   } mip_out_type;

   typedef struct packed {
      logic                           is_csr;
      logic [mbr_pkg::CSR_IDX_W-1:0]  reg_idx;
      logic [mbr_pkg::CSR_DATA_W-1:0] reg_data;
      mbr_pkg::pixel_type             px;
      logic                           typed;
      mip_out_type                    want;
   } script_row_type;

   localparam logic        ROW_PIX  = 1'b0;
   localparam logic        ROW_CSR  = 1'b1;
   localparam mip_out_type NO_CHECK = '0;

   localparam script_row_type SCRIPT [33] = '{
      // reset state is 1x1 linear: every pixel comes straight back as the last one
      '{ROW_PIX, '0, '0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1}},
      '{ROW_PIX, '0, '0, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b1}},
      '{ROW_PIX, '0, '0, 32'h55AA_01FE, 1'b1, '{32'h55AA_01FE, 1'b1}},
      '{ROW_CSR, mbr_pkg::CSR_SRGB_MODE, 13'd1, '0, 1'b0, NO_CHECK},
      '{ROW_PIX, '0, '0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1}},
      '{ROW_PIX, '0, '0, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b1}},
      '{ROW_PIX, '0, '0, 32'h8040_C001, 1'b0, NO_CHECK},
      // 2x2 in sRGB
      '{ROW_CSR, mbr_pkg::CSR_SRC_WIDTH, 13'd2, '0, 1'b0, NO_CHECK},
      '{ROW_CSR, mbr_pkg::CSR_SRC_HEIGHT, 13'd2, '0, 1'b0, NO_CHECK},
      '{ROW_PIX, '0, '0, 32'hFF00_0000, 1'b0, NO_CHECK},
      '{ROW_PIX, '0, '0, 32'h00FF_FFFF, 1'b0, NO_CHECK},
      '{ROW_PIX, '0, '0, 32'h7F80_8001, 1'b0, NO_CHECK},
      '{ROW_PIX, '0, '0, 32'h0000_0000, 1'b0, NO_CHECK},
      // 2x2 linear, one saturated corner
      '{ROW_CSR, mbr_pkg::CSR_SRGB_MODE, 13'd0, '0, 1'b0, NO_CHECK},
      '{ROW_PIX, '0, '0, 32'hFFFF_FFFF, 1'b0, NO_CHECK},
      '{ROW_PIX, '0, '0, 32'h0000_0000, 1'b0, NO_CHECK},
      '{ROW_PIX, '0, '0, 32'h0000_0000, 1'b0, NO_CHECK},
      '{ROW_PIX, '0, '0, 32'h0000_0000, 1'b1, '{32'h4040_4040, 1'b1}},
      // zero sizes behave as 1
      '{ROW_CSR, mbr_pkg::CSR_SRC_WIDTH, 13'd0, '0, 1'b0, NO_CHECK},
      '{ROW_CSR, mbr_pkg::CSR_SRC_HEIGHT, 13'd0, '0, 1'b0, NO_CHECK},
      '{ROW_PIX, '0, '0, 32'h1234_5678, 1'b1, '{32'h1234_5678, 1'b1}},
      // 3x3 drops the odd row and column; spare index write mid-level must not restart
      '{ROW_CSR, mbr_pkg::CSR_SRC_WIDTH, 13'd3, '0, 1'b0, NO_CHECK},
      '{ROW_CSR, mbr_pkg::CSR_SRC_HEIGHT, 13'd3, '0, 1'b0, NO_CHECK},
      '{ROW_PIX, '0, '0, 32'h0102_0304, 1'b0, NO_CHECK},
      '{ROW_PIX, '0, '0, 32'hFEFD_FCFB, 1'b0, NO_CHECK},
      '{ROW_PIX, '0, '0, 32'h1020_3040, 1'b0, NO_CHECK},
      '{ROW_PIX, '0, '0, 32'h8080_8080, 1'b0, NO_CHECK},
      '{ROW_CSR, CSR_SPARE, 13'd5, '0, 1'b0, NO_CHECK},
      '{ROW_PIX, '0, '0, 32'hC0C0_C0C0, 1'b0, NO_CHECK},
      '{ROW_PIX, '0, '0, 32'h0F1E_2D3C, 1'b0, NO_CHECK},
      '{ROW_PIX, '0, '0, 32'hAAAA_AAAA, 1'b0, NO_CHECK},
      '{ROW_PIX, '0, '0, 32'h5555_5555, 1'b0, NO_CHECK},
      '{ROW_PIX, '0, '0, 32'h7777_7777, 1'b0, NO_CHECK}
   };

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_wr_en = 1'b0;
   logic [mbr_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [mbr_pkg::CSR_DATA_W-1:0] csr_wr_data = '0;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [7:0]                     req_red = '0;
   logic [7:0]                     req_green = '0;
   logic [7:0]                     req_blue = '0;
   logic [7:0]                     req_alpha = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [7:0]                     rsp_red;
   logic [7:0]                     rsp_green;
   logic [7:0]                     rsp_blue;
   logic [7:0]                     rsp_alpha;
   logic                           rsp_last_of_level;

   // shadow of the block
   logic [12:0]         cfg_width = 13'd1;
   logic [12:0]         cfg_height = 13'd1;
   logic                cfg_srgb = 1'b0;
   int unsigned         col_pos = 0;
   int unsigned         row_pos = 0;
   mbr_pkg::pixel_type  held_left = '0;
   mbr_pkg::pixel_type  line_buf [mbr_pkg::MAX_WIDTH];
   logic [15:0]         code_to_lin [256];
   logic [15:0]         lin_floor [256];

   mip_out_type  reduced_due [$];
   mip_out_type  head;
   int           errors = 0;
   int           cycle_count = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;

   mip_box_reduce_srgb dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_alpha         (req_alpha),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_alpha         (rsp_alpha),
      .rsp_last_of_level (rsp_last_of_level)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
      return (a * b) >> 30;
   endfunction

   // 65535 * sRGB-to-linear(num/den); t^2.4 taken as t^2 times a truncated fifth root of t^2
   function automatic logic [15:0] curve_to_q16(longint unsigned num, longint unsigned den,
                                                bit round_up);
      longint unsigned t, t2, lo, hi, mid, r2, n, d;
      if (num * 100000 <= 4045 * den) begin
         n = 6553500 * num;
         d = 1292 * den;
      end else begin
         t = ((1000 * num + 55 * den) << 30) / (1055 * den);
         if (t > UNIT_Q30) begin
            t = UNIT_Q30;
         end
         t2 = q30_mul(t, t);
         lo = 0;
         hi = UNIT_Q30;
         while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            r2 = q30_mul(mid, mid);
            if (q30_mul(q30_mul(r2, r2), mid) <= t2) begin
               lo = mid;
            end else begin
               hi = mid - 1;
            end
         end
         n = q30_mul(t2, lo) * 65535;
         d = UNIT_Q30;
      end
      if (round_up) begin
         return 16'((n + d - 1) / d);
      end
      return 16'((n + d / 2) / d);
   endfunction

   function automatic logic [7:0] box_channel(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                              logic [7:0] d, bit linear_light);
      logic [17:0] lin_avg;
      logic [7:0]  code;
      if (!linear_light) begin
         return 8'((10'(a) + b + c + d + 2) >> 2);
      end
      lin_avg = (18'(code_to_lin[a]) + code_to_lin[b] + code_to_lin[c] + code_to_lin[d]
                 + 18'd2) >> 2;
      code = '0;
      for (int k = 1; k < 256; k++) begin
         if (lin_floor[k] <= lin_avg) begin
            code = 8'(k);
         end
      end
      return code;
   endfunction

   function automatic int unsigned eff_dim(logic [12:0] v, int unsigned maxv);
      if (v == 0) begin
         return 1;
      end
      return (v > maxv) ? maxv : v;
   endfunction

   // Advances the shadow level by one source pixel; returns 1 when a box completes.
   function automatic bit step_level(input mbr_pkg::pixel_type cur, output mip_out_type res);
      int unsigned         w, h, dw, dh, x, y;
      mbr_pkg::pixel_type  left, top_l, top_r;
      bit                  hit;
      w = eff_dim(cfg_width, mbr_pkg::MAX_WIDTH);
      h = eff_dim(cfg_height, mbr_pkg::MAX_HEIGHT);
      dw = (w > 1) ? w / 2 : 1;
      dh = (h > 1) ? h / 2 : 1;
      x = col_pos;
      y = row_pos;
      if (x >= w || y >= h) begin
         x = 0;
         y = 0;
      end
      left = (w == 1) ? cur : held_left;
      if (h == 1) begin
         top_l = left;
         top_r = cur;
      end else begin
         top_l = line_buf[((w == 1) ? x : x - 1) % mbr_pkg::MAX_WIDTH];
         top_r = line_buf[x % mbr_pkg::MAX_WIDTH];
      end
      hit = (w == 1 || (x[0] && x < 2 * dw)) && (h == 1 || (y[0] && y < 2 * dh));
      res = '0;
      if (hit) begin
         res.px.red   = box_channel(top_l.red, top_r.red, left.red, cur.red, cfg_srgb);
         res.px.green = box_channel(top_l.green, top_r.green, left.green, cur.green, cfg_srgb);
         res.px.blue  = box_channel(top_l.blue, top_r.blue, left.blue, cur.blue, cfg_srgb);
         res.px.alpha = box_channel(top_l.alpha, top_r.alpha, left.alpha, cur.alpha, 1'b0);
         res.last     = ((x >> 1) == dw - 1) && ((y >> 1) == dh - 1);
      end
      if (h > 1 && !y[0]) begin
         line_buf[x % mbr_pkg::MAX_WIDTH] = cur;
      end
      if (!x[0]) begin
         held_left = cur;
      end
      x++;
      if (x >= w) begin
         x = 0;
         y++;
         if (y >= h) begin
            y = 0;
         end
      end
      col_pos = x;
      row_pos = y;
      return hit;
   endfunction

   task automatic csr_write(input logic [mbr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [mbr_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         mbr_pkg::CSR_SRC_WIDTH:  cfg_width = data;
         mbr_pkg::CSR_SRC_HEIGHT: cfg_height = data;
         mbr_pkg::CSR_SRGB_MODE:  cfg_srgb = data[0];
         default:                 return;
      endcase
      col_pos = 0;
      row_pos = 0;
      held_left = '0;
   endtask

   task automatic push_pixel(input mbr_pkg::pixel_type px, input bit typed,
                             input mip_out_type want);
      mip_out_type guess;
      bit          hit;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_red <= px.red;
      req_green <= px.green;
      req_blue <= px.blue;
      req_alpha <= px.alpha;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      hit = step_level(px, guess);
      if (hit || typed) begin
         reduced_due.push_back(typed ? want : guess);
      end
   endtask

   // Drop valid, let every pending pixel come out, then give the pipe time to empty.
   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (reduced_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (reduced_due.size() == 0) begin
            $error("unexpected beat: red %0h green %0h blue %0h alpha %0h last %0b",
                   rsp_red, rsp_green, rsp_blue, rsp_alpha, rsp_last_of_level);
            errors++;
         end else begin
            head = reduced_due.pop_front();
            if (rsp_red !== head.px.red) begin
               $error("red: expected %0h, got %0h", head.px.red, rsp_red);
               errors++;
            end
            if (rsp_green !== head.px.green) begin
               $error("green: expected %0h, got %0h", head.px.green, rsp_green);
               errors++;
            end
            if (rsp_blue !== head.px.blue) begin
               $error("blue: expected %0h, got %0h", head.px.blue, rsp_blue);
               errors++;
            end
            if (rsp_alpha !== head.px.alpha) begin
               $error("alpha: expected %0h, got %0h", head.px.alpha, rsp_alpha);
               errors++;
            end
            if (rsp_last_of_level !== head.last) begin
               $error("last_of_level: expected %0b, got %0b", head.last, rsp_last_of_level);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int                  fed;
      int                  phase;
      int                  n;
      mbr_pkg::pixel_type  px;
      for (int k = 0; k < 256; k++) begin
         code_to_lin[k] = curve_to_q16(k, 255, 1'b0);
         lin_floor[k] = (k == 0) ? 16'd0 : curve_to_q16(2 * k - 1, 510, 1'b1);
      end
      foreach (line_buf[i]) begin
         line_buf[i] = '0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(SCRIPT); i++) begin
         if (SCRIPT[i].is_csr) begin
            quiesce();
            csr_write(SCRIPT[i].reg_idx, SCRIPT[i].reg_data);
         end else begin
            push_pixel(SCRIPT[i].px, SCRIPT[i].typed, SCRIPT[i].want);
         end
      end
      quiesce();

      fed = 0;
      phase = 0;
      while (fed < RANDOM_ITEMS) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
         endcase
         case ($urandom_range(9))
            0: begin
               // widest rows or a zero width, cut short: full levels would take thousands of beats
               case ($urandom_range(3))
                  0: csr_write(mbr_pkg::CSR_SRC_WIDTH, 13'd0);
                  1: csr_write(mbr_pkg::CSR_SRC_WIDTH, 13'd4096);
                  2: csr_write(mbr_pkg::CSR_SRC_WIDTH, 13'd4097);
                  default: csr_write(mbr_pkg::CSR_SRC_WIDTH, 13'd8191);
               endcase
               csr_write(mbr_pkg::CSR_SRC_HEIGHT, $urandom_range(1) ? 13'd1 : 13'd0);
               n = $urandom_range(20, 80);
            end
            1: begin
               csr_write(mbr_pkg::CSR_SRC_WIDTH, 13'($urandom_range(1, 3)));
               csr_write(mbr_pkg::CSR_SRC_HEIGHT, $urandom_range(1) ? 13'd4096 : 13'd8191);
               n = $urandom_range(30, 90);
            end
            default: begin
               // without a write the level carries on from where the last phase stopped
               if (eff_dim(cfg_width, mbr_pkg::MAX_WIDTH) > 16
                   || eff_dim(cfg_height, mbr_pkg::MAX_HEIGHT) > 8
                   || $urandom_range(3) != 0) begin
                  csr_write(mbr_pkg::CSR_SRC_WIDTH, ($urandom_range(2) == 0) ?
                            13'($urandom_range(1, 2)) : 13'($urandom_range(1, 16)));
                  csr_write(mbr_pkg::CSR_SRC_HEIGHT, ($urandom_range(2) == 0) ?
                            13'($urandom_range(1, 2)) : 13'($urandom_range(1, 8)));
               end
               n = int'(eff_dim(cfg_width, mbr_pkg::MAX_WIDTH)
                        * eff_dim(cfg_height, mbr_pkg::MAX_HEIGHT))
                   * $urandom_range(1, 3);
               if ($urandom_range(4) == 0) begin
                  n = $urandom_range(1, n);
               end
            end
         endcase
         // keep the total near the item budget
         if (n > RANDOM_ITEMS - fed) begin
            n = RANDOM_ITEMS - fed;
         end
         if ($urandom_range(1)) begin
            csr_write(mbr_pkg::CSR_SRGB_MODE, 13'($urandom_range(1)));
         end
         if ($urandom_range(9) == 0) begin
            csr_write(CSR_SPARE, 13'($urandom));
         end
         for (int i = 0; i < n; i++) begin
            px = $urandom;
            if ($urandom_range(5) == 0) begin
               // saturated channels hit both ends of the curve
               px.red   = $urandom_range(1) ? 8'hFF : 8'h00;
               px.green = $urandom_range(1) ? 8'hFF : 8'h00;
               px.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
               px.alpha = $urandom_range(1) ? 8'hFF : 8'h00;
            end
            push_pixel(px, 1'b0, NO_CHECK);
         end
         quiesce();
         fed += n;
         phase++;
      end

      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
